[hw/rtl/lpcd_pkg.sv]
package lpcd_pkg;

  // Byte role codes
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_NAMELEN = 3'd1;
  localparam logic [2:0] ROLE_PLEN_HI = 3'd2;
  localparam logic [2:0] ROLE_PLEN_LO = 3'd3;
  localparam logic [2:0] ROLE_NAME    = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

  localparam logic [3:0] OPCODE_MAX       = 4'd7;
  localparam logic [3:0] OPCODE_UNDEFINED = 4'd8;
  localparam logic [2:0] TRIGGER_RESET    = 3'd3;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [7:0] data_out;
    logic [3:0] packet_opcode;
    logic       packet_done;
  } lpcd_result_t;

endpackage

[hw/rtl/lpcd_parser.sv]
module lpcd_parser import lpcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         beat,
  input  logic [7:0]   data_byte,
  input  logic [2:0]   trigger_opcode,
  output lpcd_result_t result
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAMELEN = 3'd1;
  localparam logic [2:0] PH_PLEN_HI = 3'd2;
  localparam logic [2:0] PH_PLEN_LO = 3'd3;
  localparam logic [2:0] PH_NAME    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic [7:0]  name_left, name_left_next;
  logic [15:0] pay_left, pay_left_next;
  logic [7:0]  len_hi, len_hi_next;

  logic        is_trig;
  logic [15:0] pay_full;
  logic [7:0]  name_dec;
  logic [15:0] pay_dec;
  logic [3:0]  hdr_opcode;

  assign is_trig  = (cur_opcode == {1'b0, trigger_opcode});
  assign pay_full = {len_hi, data_byte};
  assign name_dec = name_left - 8'd1;
  assign pay_dec  = pay_left - 16'd1;
  assign hdr_opcode = (data_byte[3:0] > OPCODE_MAX) ? OPCODE_UNDEFINED : data_byte[3:0];

  always_comb begin
    phase_next      = phase;
    cur_opcode_next = cur_opcode;
    name_left_next  = name_left;
    pay_left_next   = pay_left;
    len_hi_next     = len_hi;
    result.byte_role = ROLE_HEADER;
    result.data_out  = data_byte;
    result.packet_done = 1'b0;
    unique case (phase)
      PH_NAMELEN: begin
        result.byte_role = ROLE_NAMELEN;
        name_left_next   = data_byte;
        if (is_trig) begin
          phase_next = PH_PLEN_HI;
        end else if (data_byte == 8'd0) begin
          phase_next = PH_HEADER;
          result.packet_done = 1'b1;
        end else begin
          phase_next = PH_NAME;
        end
      end
      PH_PLEN_HI: begin
        result.byte_role = ROLE_PLEN_HI;
        len_hi_next = data_byte;
        phase_next  = PH_PLEN_LO;
      end
      PH_PLEN_LO: begin
        result.byte_role = ROLE_PLEN_LO;
        pay_left_next    = pay_full;
        if (name_left != 8'd0) begin
          phase_next = PH_NAME;
        end else if (is_trig && pay_full != 16'd0) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next = PH_HEADER;
          result.packet_done = 1'b1;
        end
      end
      PH_NAME: begin
        result.byte_role = ROLE_NAME;
        name_left_next   = name_dec;
        if (name_dec == 8'd0) begin
          // end of name: payload only if trigger with bytes pending
          if (is_trig && pay_left != 16'd0) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_HEADER;
            result.packet_done = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        result.byte_role = ROLE_PAYLOAD;
        pay_left_next    = pay_dec;
        if (pay_dec == 16'd0) begin
          phase_next = PH_HEADER;
          result.packet_done = 1'b1;
        end
      end
      default: begin
        // header, and unused codes
        cur_opcode_next = hdr_opcode;
        phase_next      = PH_NAMELEN;
      end
    endcase
    result.packet_opcode = cur_opcode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      cur_opcode <= 4'd0;
      name_left  <= 8'd0;
      pay_left   <= 16'd0;
      len_hi     <= 8'd0;
    end else if (beat) begin
      phase      <= phase_next;
      cur_opcode <= cur_opcode_next;
      name_left  <= name_left_next;
      pay_left   <= pay_left_next;
      len_hi     <= len_hi_next;
    end
  end

endmodule

[hw/rtl/lpcd_outbuf.sv]
module lpcd_outbuf import lpcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lpcd_result_t push_item,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output lpcd_result_t out_item
);

  logic         skid_valid;
  lpcd_result_t skid_item;
  logic         take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_item <= push_item;
      end else begin
        skid_item <= push_item;
      end
    end
  end

endmodule

[hw/rtl/length_prefixed_command_deframer_unit.sv]
// Command packet deframer: takes one stream byte per beat and returns one
// tagged beat per input byte (role, byte, packet opcode, end-of-packet flag).
// Throughput is one byte per clock while in_stall is low; each result is
// formed combinationally from its byte and the parser state and captured in
// the output buffer. A two-entry output buffer (result register plus skid
// entry) lets input keep flowing while the consumer stalls; in_stall rises
// only once both entries hold unread beats. The trigger_opcode register
// (reset 3) may be written only when no beat is in flight.
module length_prefixed_command_deframer_unit import lpcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  // tagged byte output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] byte_role,
  output logic [7:0] data_out,
  output logic [3:0] packet_opcode,
  output logic       packet_done
);

  logic [2:0]   trigger_opcode;
  logic         beat;
  logic         full;
  lpcd_result_t result;
  lpcd_result_t out_item;

  // trigger opcode register
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_opcode <= TRIGGER_RESET;
    end else if (cfg_wr_en) begin
      trigger_opcode <= cfg_wr_data;
    end
  end

  assign in_stall = full;
  assign beat     = in_valid && !full;

  // parser: packet state and per-byte tagging
  lpcd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .beat           (beat),
    .data_byte      (data_byte),
    .trigger_opcode (trigger_opcode),
    .result         (result)
  );

  // result register with skid entry
  lpcd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (beat),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign byte_role     = out_item.byte_role;
  assign data_out      = out_item.data_out;
  assign packet_opcode = out_item.packet_opcode;
  assign packet_done   = out_item.packet_done;

endmodule

[hw/rtl/lpcd_checker.sv]
module lpcd_checker import lpcd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] byte_role,
  input logic [7:0] data_out,
  input logic [3:0] packet_opcode,
  input logic       packet_done
);

  // output held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_role) && $stable(data_out)
      && $stable(packet_opcode) && $stable(packet_done))
    else $error("output beat changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // accepted byte into an empty output shows next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("accepted byte not presented");

  // a header never completes a packet
  a_header_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_HEADER |-> !packet_done)
    else $error("header beat flagged as packet end");

  // opcode in range
  a_opcode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_opcode <= OPCODE_UNDEFINED)
    else $error("packet opcode out of range");

endmodule

bind length_prefixed_command_deframer_unit lpcd_checker u_lpcd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .byte_role     (byte_role),
  .data_out      (data_out),
  .packet_opcode (packet_opcode),
  .packet_done   (packet_done)
);

[dv/tb_length_prefixed_command_deframer_unit.sv]
`timescale 1ns / 1ps

module tb_length_prefixed_command_deframer_unit;
  import lpcd_pkg::*;

  // Run shape
  localparam int BYTE_TARGET  = 1250;  // stop offering new stimulus past this many beats
  localparam int DRAIN_CYCLES = 4;     // margin after the output drains, before a cfg write
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 2000;  // watchdog: cycles without any accepted beat
  localparam int REPORT_MAX   = 10;

  // Parser position in the packet, tracked by the predictor and used by the
  // stimulus generator to stay frame-aligned.
  typedef enum logic [2:0] {
    EXPECT_HEADER,
    EXPECT_NAMELEN,
    EXPECT_PLEN_HI,
    EXPECT_PLEN_LO,
    IN_NAME,
    IN_PAYLOAD
  } parse_phase_e;

  // Receiver back-pressure patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the tag for each accepted byte and checks the output
  // beats against the oldest prediction.
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    logic [2:0]   trigger_op;
    parse_phase_e phase;
    logic [3:0]   cur_op;
    logic [7:0]   name_left;
    logic [15:0]  pay_left;
    logic [7:0]   len_hi;
    lpcd_result_t expected_tags[$];
    int           accepted;
    int           checked;
    int           mismatches;

    function new();
      trigger_op = TRIGGER_RESET;
      phase      = EXPECT_HEADER;
      cur_op     = '0;
      name_left  = '0;
      pay_left   = '0;
      len_hi     = '0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_trigger(logic [2:0] v);
      trigger_op = v;
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    // Trigger is re-evaluated at every decision point, not latched per packet.
    function bit is_trigger();
      return cur_op == {1'b0, trigger_op};
    endfunction

    // End of name (or empty name): go to payload, or close the packet.
    function bit close_name();
      if (is_trigger() && pay_left != 0) begin
        phase = IN_PAYLOAD;
        return 1'b0;
      end
      phase = EXPECT_HEADER;
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      lpcd_result_t tag;
      logic [2:0]   role;
      bit           done;
      done = 1'b0;
      case (phase)
        EXPECT_NAMELEN: begin
          role      = ROLE_NAMELEN;
          name_left = b;
          if (is_trigger()) begin
            phase = EXPECT_PLEN_HI;
          end else if (b == 0) begin
            phase = EXPECT_HEADER;
            done  = 1'b1;
          end else begin
            phase = IN_NAME;
          end
        end
        EXPECT_PLEN_HI: begin
          role   = ROLE_PLEN_HI;
          len_hi = b;
          phase  = EXPECT_PLEN_LO;
        end
        EXPECT_PLEN_LO: begin
          role     = ROLE_PLEN_LO;
          pay_left = {len_hi, b};
          if (name_left != 0) phase = IN_NAME;
          else done = close_name();
        end
        IN_NAME: begin
          role      = ROLE_NAME;
          name_left = name_left - 8'd1;
          if (name_left == 0) done = close_name();
        end
        IN_PAYLOAD: begin
          role     = ROLE_PAYLOAD;
          pay_left = pay_left - 16'd1;
          if (pay_left == 0) begin
            phase = EXPECT_HEADER;
            done  = 1'b1;
          end
        end
        default: begin
          role   = ROLE_HEADER;
          cur_op = (b[3:0] > OPCODE_MAX) ? OPCODE_UNDEFINED : b[3:0];
          phase  = EXPECT_NAMELEN;
        end
      endcase
      tag.byte_role     = role;
      tag.data_out      = b;
      tag.packet_opcode = cur_op;
      tag.packet_done   = done;
      expected_tags.push_back(tag);
      accepted++;
    endfunction

    function void check_tag(lpcd_result_t got);
      lpcd_result_t want;
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected output beat: role %0d byte %02h op %0d done %0b",
                   $realtime, got.byte_role, got.data_out, got.packet_opcode,
                   got.packet_done);
        return;
      end
      want = expected_tags.pop_front();
      if (got.byte_role !== want.byte_role || got.data_out !== want.data_out ||
          got.packet_opcode !== want.packet_opcode ||
          got.packet_done !== want.packet_done) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"[%0t] beat %0d mismatch: expected role %0d byte %02h op %0d done %0b,",
                    " got role %0d byte %02h op %0d done %0b"},
                   $realtime, checked, want.byte_role, want.data_out,
                   want.packet_opcode, want.packet_done, got.byte_role, got.data_out,
                   got.packet_opcode, got.packet_done);
      end
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its pins
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] byte_role;
  logic [7:0] data_out;
  logic [3:0] packet_opcode;
  logic       packet_done;

  length_prefixed_command_deframer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_role    (byte_role),
    .data_out     (data_out),
    .packet_opcode(packet_opcode),
    .packet_done  (packet_done)
  );

  deframe_scoreboard sb;
  int burst_left;   // beats left in the current sender burst
  bit hold_req;     // main flow asks the receiver for one long hold-off
  int idle_cycles;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Output monitor and watchdog. Everything is sampled at the rising edge,
  // before any of this edge's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_tag('{byte_role, data_out, packet_opcode, packet_done});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: back-pressure in random modes of random length, plus one long
  // hold-off on request so the two-entry output buffer fills and in_stall
  // backs up into the sender.
  // --------------------------------------------------------------------------
  initial begin
    stall_mode_e rx_mode;
    int          rx_left;
    rx_mode = RX_FREE;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = stall_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Every task is entered and left at a rising edge.
  // --------------------------------------------------------------------------

  // One byte beat. Gaps come between bursts; valid stays high inside a burst.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called with nothing in flight.
  task automatic write_trigger(input logic [2:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_trigger(v);
  endtask

  // Feed random content until the parser is back at a header; the payload
  // length high byte stays small so the filler never runs long.
  task automatic finish_packet();
    while (sb.phase != EXPECT_HEADER) begin
      if (sb.phase == EXPECT_PLEN_HI) send_byte(8'($urandom_range(0, 1)));
      else send_byte(8'($urandom));
    end
  endtask

  // Well-formed packet; the length bytes go out only if the parser asks for
  // them under the current trigger setting.
  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] name_len,
                             input logic [15:0] pay_len);
    finish_packet();
    send_byte(hdr);
    send_byte(name_len);
    if (sb.phase == EXPECT_PLEN_HI) begin
      send_byte(pay_len[15:8]);
      send_byte(pay_len[7:0]);
    end
    finish_packet();
  endtask

  // Random junk. The payload length high byte is kept small so a desynced
  // stream never commits to tens of thousands of payload beats.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      if (sb.phase == EXPECT_PLEN_HI) send_byte(8'($urandom_range(0, 1)));
      else send_byte(8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_header();
    int         r;
    logic [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 30)      op = {1'b0, sb.trigger_op};
    else if (r < 85) op = 4'($urandom_range(0, 7));
    else             op = 4'($urandom_range(8, 15));
    return {4'($urandom), op};
  endfunction

  // Mostly short names; an occasional maximum-length one.
  function automatic logic [7:0] pick_name_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 4));
    if (r < 90) return 8'($urandom_range(5, 24));
    if (r < 98) return 8'($urandom_range(25, 80));
    return 8'd255;
  endfunction

  function automatic logic [15:0] pick_pay_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 10));
    if (r < 97) return 16'($urandom_range(11, 64));
    return 16'($urandom_range(256, 400));
  endfunction

  // --------------------------------------------------------------------------
  // Main flow
  // --------------------------------------------------------------------------
  initial begin
    int phase_no;
    int budget;
    sb          = new();
    burst_left  = 0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    out_stall   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: runs with the reset trigger opcode (3) ----
    // Opcodes 0 to 8 and 15 with an empty name; 8 and 15 land on undefined, 3 is the
    // trigger and needs a zero payload length to close.
    for (int op = 0; op <= 8; op++) send_packet({4'(op + 5), 4'(op)}, 8'd0, 16'd0);
    send_packet(8'h0F, 8'd0, 16'd0);
    send_packet(8'hF3, 8'd0, 16'd2);     // empty name, payload follows
    send_packet(8'h53, 8'd1, 16'd0);     // empty payload: last name byte closes

    // Trigger dropped mid-name: a 0xFFFF payload length is announced but the
    // packet closes at the end of the name.
    send_byte(8'h03);
    send_byte(8'd2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();
    write_trigger(3'd7);
    send_byte(8'hFF);
    send_packet(8'h07, 8'd0, 16'd0);     // clears the stale payload count

    // Packet becomes trigger mid-name with nothing pending: closes on the name.
    send_byte(8'h01);
    send_byte(8'd1);
    drain();
    write_trigger(3'd1);
    send_byte(8'hA5);

    // ---- random: phases separated by idle points with a register write ----
    phase_no = 0;
    while (sb.accepted < BYTE_TARGET) begin
      phase_no++;
      drain();
      case (phase_no)
        1:       write_trigger(3'd0);
        2:       write_trigger(3'd7);
        default: write_trigger(3'($urandom));
      endcase
      if (phase_no == 3) hold_req = 1'b1;   // sender keeps offering through it
      budget = sb.accepted + $urandom_range(60, 140);
      while (sb.accepted < budget) begin
        if ($urandom_range(0, 99) < 88) send_packet(pick_header(), pick_name_len(),
                                                    pick_pay_len());
        else send_noise();
        // one mid-phase pause until the output has fully caught up
        if (phase_no == 5 && sb.accepted > budget - 40) begin
          drain();
          phase_no++;
        end
      end
      // often leave the stream mid-packet so the next write lands there
      if ($urandom_range(0, 1) == 0) send_noise();
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
